// File: hw/rtl/srpm_pkg.sv
// Shared types and constants for the stereo RMS and peak dB meter.
// No dependencies; every other file of the meter except srpm_req_if imports this package.
`timescale 1ns / 1ps
`default_nettype none

package srpm_pkg;

   // Width of the per-channel square sums, which saturate at all ones.
   localparam int SUM_W  = 64;
   // Log2 results carry a 6-bit integer part and 16 fraction bits.
   localparam int FRAC_W = 16;
   localparam int MSB_W  = 6;
   localparam int LOG_W  = MSB_W + FRAC_W;
   // Signed exponent and dB scale widths.
   localparam int EXP_W  = 24;
   localparam int K_W    = 27;
   localparam int PROD_W = EXP_W + K_W;
   localparam int DB_W   = 16;

   // 256*10*log10(2) and 256*20*log10(2) in Q16.
   localparam logic [K_W-1:0] K_POWER = 27'd50504453;
   localparam logic [K_W-1:0] K_AMPL  = 27'd101008905;

   // Lowest level reported, -100 dB in 1/256 dB steps.
   localparam logic [DB_W-1:0] DB_FLOOR_MAG = 16'd25600;
   localparam logic signed [DB_W-1:0] DB_FLOOR = -16'sd25600;

   // Sequencer of the top level.
   typedef enum logic [3:0] {
      CTL_ACC   = 4'b0001,
      CTL_DRAIN = 4'b0010,
      CTL_LOG   = 4'b0100,
      CTL_DB    = 4'b1000
   } ctl_state_type;

   // Sequencer of the log2 unit.
   typedef enum logic [2:0] {
      LG_IDLE = 3'b001,
      LG_NORM = 3'b010,
      LG_SQR  = 3'b100
   } log_state_type;

   // Pipeline occupancy reported by an accumulator lane.
   typedef struct packed {
      logic mag_valid;
      logic sq_valid;
   } lane_status_type;

   // Quantities that read as silence regardless of their log.
   typedef struct packed {
      logic left_zero;
      logic right_zero;
      logic peak_zero;
   } zero_flags_type;

endpackage

`default_nettype wire

// File: hw/rtl/srpm_req_if.sv
// Sample channel of the meter: valid, ready and one stereo word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface srpm_req_if #(
   parameter int SAMPLE_BITS = 24
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;
   logic                          block_end;

   modport source (output valid, left_sample, right_sample, block_end, input ready);
   modport sink   (input valid, left_sample, right_sample, block_end, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/srpm_rsp_if.sv
// Level channel of the meter: valid, ready and four dB levels.
// Depends on srpm_pkg for the level width.
`timescale 1ns / 1ps
`default_nettype none

interface srpm_rsp_if import srpm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [DB_W-1:0] left_level_db;
   logic signed [DB_W-1:0] right_level_db;
   logic signed [DB_W-1:0] peak_level_db;
   logic signed [DB_W-1:0] loudness_db;

   modport source (output valid, left_level_db, right_level_db, peak_level_db,
                   loudness_db, input ready);
   modport sink   (input valid, left_level_db, right_level_db, peak_level_db,
                   loudness_db, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/stereo_rms_peak_db_meter.sv
// Stereo RMS and peak level meter with outputs in 1/256 dB.
// Uses srpm_pkg, srpm_req_if, srpm_rsp_if, srpm_acc_lane, srpm_log2, srpm_db_merge.
//
// req_chan carries stereo sample words (signed, SAMPLE_BITS each) with a
// block_end flag. While a block is open one word is taken per cycle; each
// lane squares and sums its channel and the peak of both is kept.
// A block closes on block_end or after MAX_BLOCK words. After the closing
// word is taken, with req_chan.ready low throughout, the lane pipelines
// drain, the four log2 units start and run their 6 leading-one and 16
// squaring steps (one multiplier each), the dB scaling stages run and the
// output register is loaded; rsp_chan then presents one word of four levels.
// The output register lets the next block run while that word waits; if it
// still waits when the next block closes, that block holds until it is taken.
// Reset clears all sums, the word count and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module stereo_rms_peak_db_meter import srpm_pkg::*; #(
   parameter int MAX_BLOCK   = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   srpm_req_if.sink   req_chan,
   srpm_rsp_if.source rsp_chan
);
   localparam int CNT_W = $clog2(MAX_BLOCK + 1);

   ctl_state_type          state_ff;
   logic [CNT_W-1:0]       count_ff, count_next, n_ff;
   logic                   accept, close, drained, log_start, merge_start, load;
   lane_status_type        left_status, right_status;
   logic [SAMPLE_BITS-1:0] left_mag, right_mag, peak_ff, peak_in;
   logic [SUM_W-1:0]       left_sum, right_sum;
   zero_flags_type         zero_ff;
   logic [LOG_W-1:0]       log_left, log_right, log_count, log_peak;
   logic [3:0]             log_done;
   logic                   merge_done;
   logic signed [DB_W-1:0] left_db, right_db, peak_db, loud_db;
   logic                   rsp_valid_ff;
   logic signed [DB_W-1:0] left_db_ff, right_db_ff, peak_db_ff, loud_db_ff;

   // Handshake and block close decision.
   always_comb begin
      accept     = req_chan.valid && req_chan.ready;
      count_next = count_ff + 1'b1;
      close      = req_chan.block_end || (count_next == CNT_W'(MAX_BLOCK));
      drained    = !(left_status.mag_valid || left_status.sq_valid ||
                     right_status.mag_valid || right_status.sq_valid);
      log_start  = (state_ff == CTL_DRAIN) && drained;
      merge_start = (state_ff == CTL_LOG) && (log_done == 4'b1111);
      load       = (state_ff == CTL_DB) && merge_done &&
                   (!rsp_valid_ff || rsp_chan.ready);
   end

   assign req_chan.ready = (state_ff == CTL_ACC);

   // Channel lanes.
   srpm_acc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_left (
      .clock(clock), .reset(reset), .take(accept),
      .sample(req_chan.left_sample), .clear(log_start),
      .mag(left_mag), .status(left_status), .sum(left_sum)
   );

   srpm_acc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_right (
      .clock(clock), .reset(reset), .take(accept),
      .sample(req_chan.right_sample), .clear(log_start),
      .mag(right_mag), .status(right_status), .sum(right_sum)
   );

   // Peak across both channels.
   always_comb begin
      peak_in = peak_ff;
      if (left_mag > peak_in) begin
         peak_in = left_mag;
      end
      if (right_mag > peak_in) begin
         peak_in = right_mag;
      end
   end

   // Log2 units for both sums, the word count and the peak.
   srpm_log2 u_log_left (
      .clock(clock), .reset(reset), .start(log_start), .x(left_sum),
      .done(log_done[0]), .result(log_left)
   );

   srpm_log2 u_log_right (
      .clock(clock), .reset(reset), .start(log_start), .x(right_sum),
      .done(log_done[1]), .result(log_right)
   );

   srpm_log2 u_log_count (
      .clock(clock), .reset(reset), .start(log_start), .x(SUM_W'(n_ff)),
      .done(log_done[2]), .result(log_count)
   );

   srpm_log2 u_log_peak (
      .clock(clock), .reset(reset), .start(log_start), .x(SUM_W'(peak_ff)),
      .done(log_done[3]), .result(log_peak)
   );

   srpm_db_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
      .clock(clock), .reset(reset), .start(merge_start),
      .log_left(log_left), .log_right(log_right), .log_count(log_count),
      .log_peak(log_peak), .zero(zero_ff), .done(merge_done),
      .left_db(left_db), .right_db(right_db), .peak_db(peak_db), .loud_db(loud_db)
   );

   // Block sequencer, word count and peak.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_ACC;
         count_ff <= '0;
         peak_ff  <= '0;
      end else begin
         if (log_start) begin
            peak_ff <= '0;
         end else if (left_status.mag_valid) begin
            peak_ff <= peak_in;
         end
         unique case (state_ff)
            CTL_ACC: begin
               if (accept) begin
                  if (close) begin
                     count_ff <= '0;
                     state_ff <= CTL_DRAIN;
                  end else begin
                     count_ff <= count_next;
                  end
               end
            end
            CTL_DRAIN: begin
               if (log_start) begin
                  state_ff <= CTL_LOG;
               end
            end
            CTL_LOG: begin
               if (merge_start) begin
                  state_ff <= CTL_DB;
               end
            end
            CTL_DB: begin
               if (load) begin
                  state_ff <= CTL_ACC;
               end
            end
            default: begin
               state_ff <= CTL_ACC;
            end
         endcase
      end
   end

   // Block length captured at close, silence flags when the logs start.
   always_ff @(posedge clock) begin
      if (accept && close) begin
         n_ff <= count_next;
      end
      if (log_start) begin
         zero_ff.left_zero  <= (left_sum == '0);
         zero_ff.right_zero <= (right_sum == '0);
         zero_ff.peak_zero  <= (peak_ff == '0);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         left_db_ff  <= left_db;
         right_db_ff <= right_db;
         peak_db_ff  <= peak_db;
         loud_db_ff  <= loud_db;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.left_level_db  = left_db_ff;
   assign rsp_chan.right_level_db = right_db_ff;
   assign rsp_chan.peak_level_db  = peak_db_ff;
   assign rsp_chan.loudness_db    = loud_db_ff;

`ifndef SYNTHESIS
   // The log units must see final sums: no lane activity once they run.
   a_lanes_idle_in_log: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_LOG) |-> drained)
      else $error("lane pipeline active while logs run");

   // An open block never holds MAX_BLOCK words.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(MAX_BLOCK))
      else $error("word count reached block limit without close");

   // Loudness is the larger of the two RMS levels.
   a_loudness_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (loud_db_ff == ((left_db_ff > right_db_ff) ?
                                       left_db_ff : right_db_ff)))
      else $error("loudness differs from larger RMS level");

   // A new result only comes out of the scaling stage.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == CTL_DB))
      else $error("result word raised outside scaling state");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/srpm_acc_lane.sv
// One channel lane: magnitude, square and saturating square sum.
// Depends on srpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srpm_acc_lane import srpm_pkg::*; #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   clear,
   output logic [SAMPLE_BITS-1:0] mag,
   output lane_status_type        status,
   output logic [SUM_W-1:0]       sum
);
   localparam int WIDE_W = SUM_W + 1;

   logic [SAMPLE_BITS-1:0]   mag_ff, mag_in;
   logic                     mag_valid_ff, sq_valid_ff;
   logic [2*SAMPLE_BITS-1:0] sq_ff;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [WIDE_W-1:0]        wide_sum;

   // Absolute value; the most negative code maps to the sign weight.
   always_comb begin
      mag_in = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
   end

   // Add the square and saturate on carry out.
   always_comb begin
      wide_sum = {1'b0, sum_ff} + WIDE_W'(sq_ff);
      sum_in   = wide_sum[SUM_W] ? {SUM_W{1'b1}} : wide_sum[SUM_W-1:0];
   end

   // Stage valids and the running sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_ff       <= '0;
      end else begin
         mag_valid_ff <= take;
         sq_valid_ff  <= mag_valid_ff;
         if (clear) begin
            sum_ff <= '0;
         end else if (sq_valid_ff) begin
            sum_ff <= sum_in;
         end
      end
   end

   // Magnitude and square stages.
   always_ff @(posedge clock) begin
      if (take) begin
         mag_ff <= mag_in;
      end
      if (mag_valid_ff) begin
         sq_ff <= mag_ff * mag_ff;
      end
   end

   assign mag              = mag_ff;
   assign sum              = sum_ff;
   assign status.mag_valid = mag_valid_ff;
   assign status.sq_valid  = sq_valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/srpm_log2.sv
// Iterative log2 with 16 fraction bits: leading-one search, then squaring.
// Depends on srpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srpm_log2 import srpm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] x,
   output logic             done,
   output logic [LOG_W-1:0] result
);
   localparam int M_W = SUM_W / 2;

   log_state_type       state_ff;
   logic [SUM_W-1:0]    val_ff, val_in;
   logic [MSB_W-1:0]    msb_ff, msb_in;
   logic [MSB_W-1:0]    shift;
   logic                hi_zero;
   logic [3:0]          step_ff;
   logic [M_W-1:0]      m_ff, m_in;
   logic [2*M_W-1:0]    prod;
   logic [FRAC_W-1:0]   frac_ff;
   logic                done_ff;

   // One binary-search step of the leading-one position.
   always_comb begin
      shift   = 6'd32 >> step_ff;
      hi_zero = (val_ff & ~({SUM_W{1'b1}} >> shift)) == '0;
      val_in  = hi_zero ? (val_ff << shift) : val_ff;
      msb_in  = hi_zero ? (msb_ff - shift) : msb_ff;
   end

   // One squaring step of the normalized mantissa.
   always_comb begin
      prod = m_ff * m_ff;
      m_in = prod[2*M_W-1] ? prod[2*M_W-1:M_W] : prod[2*M_W-2:M_W-1];
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            LG_IDLE: begin
               if (start) begin
                  state_ff <= LG_NORM;
                  done_ff  <= 1'b0;
               end
            end
            LG_NORM: begin
               if (step_ff == 4'd5) begin
                  state_ff <= LG_SQR;
               end
            end
            LG_SQR: begin
               if (step_ff == 4'd0) begin
                  state_ff <= LG_IDLE;
                  done_ff  <= 1'b1;
               end
            end
            default: begin
               state_ff <= LG_IDLE;
            end
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         LG_IDLE: begin
            if (start) begin
               val_ff  <= x;
               msb_ff  <= {MSB_W{1'b1}};
               step_ff <= 4'd0;
               frac_ff <= '0;
            end
         end
         LG_NORM: begin
            val_ff <= val_in;
            msb_ff <= msb_in;
            if (step_ff == 4'd5) begin
               step_ff <= 4'd15;
               m_ff    <= val_in[SUM_W-1:M_W];
            end else begin
               step_ff <= step_ff + 4'd1;
            end
         end
         LG_SQR: begin
            m_ff             <= m_in;
            frac_ff[step_ff] <= prod[2*M_W-1];
            step_ff          <= step_ff - 4'd1;
         end
         default: begin
         end
      endcase
   end

   assign done   = done_ff;
   assign result = {msb_ff, frac_ff};

endmodule

`default_nettype wire

// File: hw/rtl/srpm_db_merge.sv
// Merging stage: exponents, dB scaling, floor and clip, loudness maximum.
// Depends on srpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srpm_db_merge import srpm_pkg::*; #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [LOG_W-1:0]       log_left,
   input  logic [LOG_W-1:0]       log_right,
   input  logic [LOG_W-1:0]       log_count,
   input  logic [LOG_W-1:0]       log_peak,
   input  zero_flags_type         zero,
   output logic                   done,
   output logic signed [DB_W-1:0] left_db,
   output logic signed [DB_W-1:0] right_db,
   output logic signed [DB_W-1:0] peak_db,
   output logic signed [DB_W-1:0] loud_db
);
   localparam logic signed [EXP_W-1:0] POW_OFS = EXP_W'(2 * (SAMPLE_BITS - 1) * 65536);
   localparam logic signed [EXP_W-1:0] AMP_OFS = EXP_W'((SAMPLE_BITS - 1) * 65536);
   localparam int Q_W   = PROD_W - 32;
   localparam int RND_W = PROD_W + 1;

   logic signed [EXP_W-1:0] expo [3];
   logic [K_W-1:0]          k_val [3];
   logic                    is_zero [3];
   logic [PROD_W-1:0]       prod_ff [3];
   logic                    clip_ff [3];
   logic                    floor_ff [3];
   logic signed [DB_W-1:0]  db_val [3];
   logic signed [DB_W-1:0]  db_ff [3];
   logic                    st1_valid_ff;
   logic                    done_ff;

   // Exponents of left power, right power and peak amplitude.
   always_comb begin
      expo[0]    = $signed({2'b00, log_left}) - $signed({2'b00, log_count}) - POW_OFS;
      expo[1]    = $signed({2'b00, log_right}) - $signed({2'b00, log_count}) - POW_OFS;
      expo[2]    = $signed({2'b00, log_peak}) - AMP_OFS;
      k_val[0]   = K_POWER;
      k_val[1]   = K_POWER;
      k_val[2]   = K_AMPL;
      is_zero[0] = zero.left_zero;
      is_zero[1] = zero.right_zero;
      is_zero[2] = zero.peak_zero;
   end

   for (genvar i = 0; i < 3; i++) begin : g_lvl
      logic [EXP_W-1:0] mag;
      logic [RND_W-1:0] rounded;
      logic [Q_W-1:0]   q;

      // Scale stage: |E| times the dB constant.
      always_comb begin
         mag = EXP_W'(0) - expo[i];
      end

      always_ff @(posedge clock) begin
         if (start) begin
            prod_ff[i]  <= mag * k_val[i];
            clip_ff[i]  <= !expo[i][EXP_W-1];
            floor_ff[i] <= is_zero[i];
         end
      end

      // Round half up, negate and apply floor and clip.
      always_comb begin
         rounded = {1'b0, prod_ff[i]} + (RND_W'(1) << 31);
         q       = rounded[PROD_W-1:32];
         if (floor_ff[i]) begin
            db_val[i] = DB_FLOOR;
         end else if (clip_ff[i]) begin
            db_val[i] = '0;
         end else if (q >= Q_W'(DB_FLOOR_MAG)) begin
            db_val[i] = DB_FLOOR;
         end else begin
            db_val[i] = $signed(DB_W'(0) - q[DB_W-1:0]);
         end
      end

      always_ff @(posedge clock) begin
         if (st1_valid_ff) begin
            db_ff[i] <= db_val[i];
         end
      end
   end

   // Stage valids; done holds until the next start.
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         st1_valid_ff <= start;
         if (start) begin
            done_ff <= 1'b0;
         end else if (st1_valid_ff) begin
            done_ff <= 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign left_db  = db_ff[0];
   assign right_db = db_ff[1];
   assign peak_db  = db_ff[2];
   assign loud_db  = (db_ff[0] > db_ff[1]) ? db_ff[0] : db_ff[1];

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the stereo RMS and peak dB meter.
// Depends on srpm_pkg, srpm_req_if, srpm_rsp_if and stereo_rms_peak_db_meter.
`timescale 1ns / 1ps

module tb;
   import srpm_pkg::*;

   localparam int MAX_BLOCK   = 4096;
   localparam int SAMPLE_BITS = 24;
   localparam int LIMIT       = 600000;
   localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 24'sh800000;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
      logic                          block_end;
   } pair_type;

   typedef struct packed {
      logic signed [DB_W-1:0] left_db;
      logic signed [DB_W-1:0] right_db;
      logic signed [DB_W-1:0] peak_db;
      logic signed [DB_W-1:0] loud_db;
   } levels_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   srpm_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   srpm_rsp_if rsp_chan ();

   stereo_rms_peak_db_meter #(.MAX_BLOCK(MAX_BLOCK), .SAMPLE_BITS(SAMPLE_BITS)) dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   pair_type   pending_pairs[$];
   levels_type expected_levels[$];
   int         errors = 0;
   int         cycle = 0;
   int         words_taken = 0;
   int         levels_seen = 0;
   int         holdoff = 0;

   // Block state of the predictor.
   longint unsigned sum_left, sum_right, peak_mag;
   int unsigned     pair_count;

   function automatic longint unsigned mag_of(logic signed [SAMPLE_BITS-1:0] s);
      logic [SAMPLE_BITS:0] wide;
      wide = s < 0 ? -{s[SAMPLE_BITS-1], s} : {1'b0, s};
      return longint'(wide);
   endfunction

   // Base-2 log with 16 fraction bits by repeated squaring of the mantissa.
   function automatic longint log2_fix(longint unsigned x);
      int msb;
      longint unsigned m;
      longint frac;
      msb = 63;
      frac = 0;
      while (msb > 0 && x[msb] == 1'b0) msb--;
      m = (x << (63 - msb)) >> 32;
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            frac |= longint'(1) << i;
            m >>= 1;
         end
      end
      return longint'(msb) * 65536 + frac;
   endfunction

   function automatic logic signed [DB_W-1:0] scale_db(longint e, longint k);
      longint unsigned mg;
      longint d;
      if (e >= 0) return '0;
      mg = longint'(-e);
      d = -longint'((mg * longint'(k) + 64'h8000_0000) >> 32);
      if (d <= -25600) return DB_FLOOR;
      return d[DB_W-1:0];
   endfunction

   function automatic logic signed [DB_W-1:0] power_db(longint unsigned s, int unsigned n);
      if (s == 0 || n == 0) return DB_FLOOR;
      return scale_db(log2_fix(s) - log2_fix(n) - longint'(2 * (SAMPLE_BITS - 1)) * 65536,
                      longint'(K_POWER));
   endfunction

   // Fold one accepted word into the block and queue levels at block close.
   task automatic meter_pair(pair_type p);
      longint unsigned ml, mr;
      levels_type lv;
      ml = mag_of(p.left_sample);
      mr = mag_of(p.right_sample);
      sum_left += ml * ml;
      sum_right += mr * mr;
      if (ml > peak_mag) peak_mag = ml;
      if (mr > peak_mag) peak_mag = mr;
      pair_count++;
      if (!p.block_end && pair_count < MAX_BLOCK) return;
      lv.left_db  = power_db(sum_left, pair_count);
      lv.right_db = power_db(sum_right, pair_count);
      lv.peak_db  = peak_mag == 0 ? DB_FLOOR :
                    scale_db(log2_fix(peak_mag) - longint'(SAMPLE_BITS - 1) * 65536,
                             longint'(K_AMPL));
      lv.loud_db  = lv.left_db > lv.right_db ? lv.left_db : lv.right_db;
      expected_levels.push_back(lv);
      sum_left = 0;
      sum_right = 0;
      peak_mag = 0;
      pair_count = 0;
   endtask

   task automatic report(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle, what, got, want);
      errors++;
   endtask

   function automatic bit quiet_stretch();
      return cycle >= 3000 && cycle < 9000;
   endfunction

   // Driver: present the next word, with random gaps, once the previous one has gone.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.left_sample <= '0;
         req_chan.right_sample <= '0;
         req_chan.block_end <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            meter_pair({req_chan.left_sample, req_chan.right_sample, req_chan.block_end});
            words_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_pairs.size() > 0 &&
                (quiet_stretch() || $urandom_range(99) >= 6)) begin
               pair_type p;
               p = pending_pairs.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.left_sample <= p.left_sample;
               req_chan.right_sample <= p.right_sample;
               req_chan.block_end <= p.block_end;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver hold-off: one long stall so the meter backs up into its input.
   always @(posedge clock) begin
      if (reset) holdoff <= 0;
      else if (cycle == 1000) holdoff <= 800;
      else if (holdoff > 0) holdoff <= holdoff - 1;
   end

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else if (holdoff > 1 || cycle == 1000) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= quiet_stretch() || $urandom_range(99) >= 6;
   end

   // Monitor: compare each level word with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         levels_seen++;
         if (expected_levels.size() == 0) begin
            $display("unexpected level word at cycle %0d", cycle);
            errors++;
         end else begin
            levels_type w;
            w = expected_levels.pop_front();
            if (rsp_chan.left_level_db !== w.left_db)
               report("left_level_db", rsp_chan.left_level_db, w.left_db);
            if (rsp_chan.right_level_db !== w.right_db)
               report("right_level_db", rsp_chan.right_level_db, w.right_db);
            if (rsp_chan.peak_level_db !== w.peak_db)
               report("peak_level_db", rsp_chan.peak_level_db, w.peak_db);
            if (rsp_chan.loudness_db !== w.loud_db)
               report("loudness_db", rsp_chan.loudness_db, w.loud_db);
         end
      end
   end

   // Cycle counter with the run limit.
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle >= LIMIT) begin
         $display("timeout with %0d level words outstanding", expected_levels.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic add_pair(logic signed [SAMPLE_BITS-1:0] l, logic signed [SAMPLE_BITS-1:0] r,
                           logic e);
      pair_type p;
      p.left_sample = l;
      p.right_sample = r;
      p.block_end = e;
      pending_pairs.push_back(p);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(5))
         0: return S_MAX;
         1: return S_MIN;
         2: return $urandom_range(15) - 8;
         3: return ($urandom >> 8) >>> $urandom_range(20);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int len;
      sum_left = 0;
      sum_right = 0;
      peak_mag = 0;
      pair_count = 0;

      // Directed: full scale, silence, smallest step and one-word blocks.
      add_pair(S_MAX, S_MAX, 1'b1);
      add_pair(S_MIN, S_MIN, 1'b1);
      add_pair(S_MIN, S_MAX, 1'b0);
      add_pair(S_MAX, S_MIN, 1'b1);
      add_pair(0, 0, 1'b1);
      add_pair(0, 0, 1'b0);
      add_pair(0, 0, 1'b1);
      add_pair(1, -1, 1'b1);
      add_pair(0, 1, 1'b1);
      add_pair(-1, 0, 1'b1);
      add_pair(24'sd84, 0, 1'b1);
      add_pair(24'sd4194304, -24'sd4194304, 1'b0);
      add_pair(24'sd83886, 24'sd838, 1'b1);
      add_pair(24'sh555555, 24'shAAAAAA, 1'b1);
      add_pair(24'shAAAAAA, 24'sh555555, 1'b1);

      // Random blocks, mostly short.
      while (pending_pairs.size() < 1250) begin
         len = $urandom_range(99) < 70 ? $urandom_range(1, 8) : $urandom_range(9, 60);
         for (int i = 0; i < len; i++)
            add_pair(rand_sample(), rand_sample(), i == len - 1);
      end
      len = pending_pairs.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      wait (words_taken == len && expected_levels.size() == 0);
      repeat (100) @(posedge clock);
      $display("%0d sample words in %0d metering blocks, from full scale to silence,", len,
               levels_seen);
      $display("with random gaps on both sides and one long output stall.");
      if (errors == 0 && expected_levels.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
